@@ rtl/rop_pkg.sv @@
// ----------------------------------------------------------------------------
// rop_pkg
// Shared types, constants and helpers for the running one-pin checker.
// ----------------------------------------------------------------------------
package rop_pkg;

  localparam int PIN_COUNT_DEFAULT = 41;
  localparam int PIN_W            = 6;   // pin index width, up to 64 pins
  localparam int PIN_CNT_W        = 7;   // holds a pin count up to 64
  localparam int ERR_W            = 12;
  localparam int TMO_W            = 16;
  localparam int DEB_W            = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 16'd5000;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 2'd3;
  localparam logic [DEB_W-1:0] SAMPLE_MAX     = 2'd3;
  localparam logic [ERR_W-1:0] ERR_MAX        = 12'd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_LIMIT  = 2'd0,
    CFG_DEBOUNCE_COUNT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [TMO_W-1:0] timeout_counter;
    logic             sync_waiting;
    logic [PIN_W-1:0] pin_index;
    logic [DEB_W-1:0] sample_count;
    logic [ERR_W-1:0] errors;
    logic             led;
  } chk_state_t;

  typedef struct packed {
    logic [ERR_W-1:0] error_count;
    logic             led_on;
    logic             in_sync_wait;
    logic [PIN_W-1:0] target_pin;
    logic             pass_done;
    logic             pass_ok;
    logic             timed_out;
  } chk_result_t;

  // debounce counter: clears on mismatch, saturates on match
  function automatic logic [DEB_W-1:0] bump_samples(logic [DEB_W-1:0] cnt, logic match);
    logic [DEB_W-1:0] res;
    res = cnt;
    if (!match) begin
      res = '0;
    end else if (cnt < SAMPLE_MAX) begin
      res = cnt + DEB_W'(1);
    end
    return res;
  endfunction

endpackage

@@ rtl/rop_tick.sv @@
// ----------------------------------------------------------------------------
// rop_tick
// Next-state and result logic for one sampled pin vector.
// ----------------------------------------------------------------------------
module rop_tick import rop_pkg::*; #(
  parameter int PIN_COUNT = PIN_COUNT_DEFAULT
) (
  input  logic [PIN_COUNT-1:0] levels,
  input  chk_state_t           cur,
  input  logic [TMO_W-1:0]     timeout_limit,
  input  logic [DEB_W-1:0]     debounce_count,
  output chk_state_t           nxt,
  output chk_result_t          res
);

  logic [PIN_COUNT-1:0] expect_vec;
  logic [PIN_COUNT-1:0] diff_vec;
  logic [PIN_CNT_W-1:0] bad;
  logic [ERR_W:0]       err_sum;
  logic [PIN_CNT_W-1:0] pin_inc;
  logic                 tout;
  logic                 done;
  logic                 ok;

  assign expect_vec = {{(PIN_COUNT-1){1'b0}}, 1'b1} << cur.pin_index;
  assign diff_vec   = levels ^ expect_vec;

  // count of pins off the one-hot pattern
  always_comb begin
    bad = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      bad = bad + PIN_CNT_W'(diff_vec[i]);
    end
  end

  assign pin_inc = {1'b0, cur.pin_index} + PIN_CNT_W'(1);

  always_comb begin
    nxt     = cur;
    tout    = 1'b0;
    done    = 1'b0;
    ok      = 1'b0;
    err_sum = '0;

    if (cur.timeout_counter >= timeout_limit) begin
      nxt.led             = 1'b0;
      nxt.sync_waiting    = 1'b1;
      nxt.pin_index       = '0;
      nxt.errors          = ERR_W'(1);
      nxt.timeout_counter = '0;
      tout                = 1'b1;
    end else begin
      nxt.timeout_counter = cur.timeout_counter + TMO_W'(1);
    end

    if (nxt.sync_waiting) begin
      nxt.sample_count = bump_samples(cur.sample_count, !levels[0]);
      if (nxt.sample_count >= debounce_count) begin
        nxt.sync_waiting    = 1'b0;
        nxt.pin_index       = '0;
        nxt.sample_count    = '0;
        nxt.errors          = '0;
        nxt.timeout_counter = '0;
      end
    end else begin
      nxt.sample_count = bump_samples(cur.sample_count, (levels & expect_vec) != '0);
      if (nxt.sample_count >= debounce_count) begin
        nxt.sample_count = '0;
        if (bad != '0) begin
          nxt.led = 1'b0;
          err_sum = {1'b0, nxt.errors} + (ERR_W+1)'(bad);
          nxt.errors = (err_sum > {1'b0, ERR_MAX}) ? ERR_MAX : err_sum[ERR_W-1:0];
        end
        nxt.pin_index = pin_inc[PIN_W-1:0];
        if (pin_inc >= PIN_CNT_W'(PIN_COUNT)) begin
          done             = 1'b1;
          ok               = (nxt.errors == '0);
          nxt.led          = ok;
          nxt.sync_waiting = 1'b1;
          nxt.pin_index    = '0;
          nxt.errors       = '0;
        end
        nxt.timeout_counter = '0;
      end
    end
  end

  always_comb begin
    res.error_count  = nxt.errors;
    res.led_on       = nxt.led;
    res.in_sync_wait = nxt.sync_waiting;
    res.target_pin   = nxt.sync_waiting ? '0 : nxt.pin_index;
    res.pass_done    = done;
    res.pass_ok      = ok;
    res.timed_out    = tout;
  end

endmodule

@@ rtl/rop_out_reg.sv @@
// ----------------------------------------------------------------------------
// rop_out_reg
// Result register with valid, held while the consumer stalls.
// ----------------------------------------------------------------------------
module rop_out_reg import rop_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  chk_result_t d,
  input  logic        stall,
  output logic        valid,
  output chk_result_t q,
  output logic        ready
);

  // free when empty or when the held result leaves this cycle
  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

@@ rtl/running_one_pin_checker.sv @@
// ----------------------------------------------------------------------------
// running_one_pin_checker
// Walking-ones interconnect checker: follows a one-hot pattern across the
// sampled pins, counts mismatching pins and reports a verdict per pass.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                    payload
//   -------   ---------  ---------------------------  -------------------------
//   pin       in         pin_valid / pin_stall        pin_levels
//   result    out        result_valid / result_stall  error_count, led_on,
//                                                     in_sync_wait, target_pin,
//                                                     pass_done, pass_ok,
//                                                     timed_out
//   cfg       in         cfg_we                       cfg_index, cfg_data
//
// one result per pin transfer; one transfer per cycle unless the result stalls
// a sample passes the input register first; the checker state and the result
//   register then update together, and the result is valid from that update
// reset returns the checker state and the config registers to their reset
//   values and clears both valid flags
// a stalled result holds in the result register; the input register keeps
//   accepting as long as the result register frees up in the same cycle
//
module running_one_pin_checker import rop_pkg::*; #(
  parameter int PIN_COUNT = PIN_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // pin sample channel
  input  logic                  pin_valid,
  output logic                  pin_stall,
  input  logic [PIN_COUNT-1:0]  pin_levels,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [ERR_W-1:0]      error_count,
  output logic                  led_on,
  output logic                  in_sync_wait,
  output logic [PIN_W-1:0]      target_pin,
  output logic                  pass_done,
  output logic                  pass_ok,
  output logic                  timed_out,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [TMO_W-1:0]     timeout_limit;
  logic [DEB_W-1:0]     debounce_count;

  // input register
  logic                 in_valid;
  logic [PIN_COUNT-1:0] levels;

  // checker state
  chk_state_t           state;
  chk_state_t           state_next;
  chk_result_t          tick_res;
  chk_result_t          out_res;

  logic                 out_ready;
  logic                 advance;
  logic                 accept;

  // the held sample moves on whenever the result register can take it
  assign advance   = in_valid && out_ready;
  assign pin_stall = in_valid && !out_ready;
  assign accept    = pin_valid && !pin_stall;

  // config writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit  <= TIMEOUT_RESET;
      debounce_count <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT_LIMIT:  timeout_limit  <= cfg_data[TMO_W-1:0];
        CFG_DEBOUNCE_COUNT: debounce_count <= cfg_data[DEB_W-1:0];
        default:            ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      levels <= pin_levels;
    end
  end

  // checker state updates once per sample, in step with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.timeout_counter <= '0;
      state.sync_waiting    <= 1'b1;
      state.pin_index       <= '0;
      state.sample_count    <= '0;
      state.errors          <= '0;
      state.led             <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  rop_tick #(
    .PIN_COUNT (PIN_COUNT)
  ) u_tick (
    .levels         (levels),
    .cur            (state),
    .timeout_limit  (timeout_limit),
    .debounce_count (debounce_count),
    .nxt            (state_next),
    .res            (tick_res)
  );

  rop_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .d     (tick_res),
    .stall (result_stall),
    .valid (result_valid),
    .q     (out_res),
    .ready (out_ready)
  );

  // result fields
  assign error_count  = out_res.error_count;
  assign led_on       = out_res.led_on;
  assign in_sync_wait = out_res.in_sync_wait;
  assign target_pin   = out_res.target_pin;
  assign pass_done    = out_res.pass_done;
  assign pass_ok      = out_res.pass_ok;
  assign timed_out    = out_res.timed_out;

endmodule
